FILE: design/pam_pkg.sv
// Shared package of the polygon area and perimeter measurement block.
// Holds field widths, constants, state machine and command/status types.
// No dependencies.
package pam_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned MM_W         = 20;
  localparam int unsigned AREA_W       = 33;
  localparam int unsigned AREA_MM_W    = 40;
  localparam int unsigned PERIM_W      = 27;
  localparam int unsigned RAD_W        = 34;
  localparam int unsigned ROOT_W       = 17;
  localparam int unsigned DIV_W        = 56;
  localparam int unsigned QUO_W        = 16;

  localparam logic [MM_W-1:0] MM_RESET    = 20'd65536;
  // round(4 * pi * 2^16)
  localparam logic [19:0]     FOUR_PI_Q16 = 20'd823550;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT,
    ST_UPD,
    ST_CHECK,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_RND,
    DIV_CX,
    DIV_CY
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     diff;
    logic     close_edge;
    logic     square;
    logic     root_go;
    logic     add_len;
    logic     upd_vtx;
    logic     fin1;
    logic     fin2;
    logic     fin3;
    logic     fin4;
    logic     div_go;
    logic     div_store;
    div_sel_e div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_ge3;
    logic last;
    logic root_done;
    logic div_done;
    logic perim_zero;
    logic out_free;
  } status_t;

endpackage

FILE: design/pam_if.sv
// Valid/ready channel interfaces of the polygon measurement block.
// One carries vertices in, the other carries measurement results out.
// No dependencies.
interface pam_vertex_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_x;
  logic [15:0] vertex_y;
  logic        last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pam_result_if;
  logic        valid;
  logic        ready;
  logic [32:0] area_px;
  logic [39:0] area_mm;
  logic [26:0] perimeter_len;
  logic [15:0] centroid_x;
  logic [15:0] centroid_y;
  logic [15:0] roundness;
  logic [15:0] box_left;
  logic [15:0] box_top;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic        valid_res;

  modport source (output valid, output area_px, output area_mm, output perimeter_len,
                  output centroid_x, output centroid_y, output roundness,
                  output box_left, output box_top, output box_width,
                  output box_height, output valid_res, input ready);
  modport sink   (input valid, input area_px, input area_mm, input perimeter_len,
                  input centroid_x, input centroid_y, input roundness,
                  input box_left, input box_top, input box_width,
                  input box_height, input valid_res, output ready);
endinterface

FILE: design/polygon_area_perimeter_measure_core.sv
// Vertices are taken one at a time: a new vertex is accepted only once the
// previous one is through; an inner vertex is dominated by the 17-step square root
// on the edge length. The last vertex of a ring of three or more then runs its
// own edge, the closing edge, the final products, up to three 16-step divisions
// (roundness, skipped for a zero perimeter, and centroid) and the result load.
// Reset (rst_ni low, asynchronous) clears accumulators, the scale to 1.0 and
// the result slot; vertex input is taken again right after reset.
//
// The block measures a polygon given as a ring of vertices. A controller
// sequences a shared datapath: for each accepted vertex transaction after the
// first, the edge from the previous vertex is formed, its cross product is added to the
// shoelace sum and its length is found by an iterative square root. The
// transaction carrying the last marker closes the ring back to the first
// vertex if the ring has three or more, then the area, scaled area, roundness
// and centroid are computed, and one result transaction is offered. The result
// waits in its own register, so next-polygon vertices are taken while it is pending.
module polygon_area_perimeter_measure_core #(
  parameter int unsigned MAX_VERTICES = pam_pkg::MAX_VERTICES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pam_pkg::MM_W-1:0]  cfg_data_i,
  pam_vertex_if.sink                vtx_i,
  pam_result_if.source              res_o
);

  pam_pkg::cmd_t    cmd;
  pam_pkg::status_t status;
  logic             in_ready;

  pam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign vtx_i.ready = in_ready;

  pam_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .vertex_x_i      (vtx_i.vertex_x),
    .vertex_y_i      (vtx_i.vertex_y),
    .last_vertex_i   (vtx_i.last_vertex),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .area_px_o       (res_o.area_px),
    .area_mm_o       (res_o.area_mm),
    .perimeter_len_o (res_o.perimeter_len),
    .centroid_x_o    (res_o.centroid_x),
    .centroid_y_o    (res_o.centroid_y),
    .roundness_o     (res_o.roundness),
    .box_left_o      (res_o.box_left),
    .box_top_o       (res_o.box_top),
    .box_width_o     (res_o.box_width),
    .box_height_o    (res_o.box_height),
    .valid_res_o     (res_o.valid_res)
  );

endmodule

FILE: design/pam_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle, rounded.
// Depends on pam_pkg.
module pam_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pam_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [pam_pkg::ROOT_W-1:0]  root_o
);

  localparam int unsigned RW    = pam_pkg::RAD_W;
  localparam int unsigned QW    = pam_pkg::ROOT_W;
  localparam int unsigned REMW  = QW + 2;
  localparam int unsigned TW    = REMW + 2;
  localparam int unsigned STEPS = RW / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [RW-1:0]   rad_q;
  logic [REMW-1:0] rem_q;
  logic [QW-1:0]   root_q;
  logic [TW-1:0]   t, trial;
  logic            fit;

  assign t     = {rem_q, rad_q[RW-1 -: 2]};
  assign trial = TW'({root_q, 2'b01});
  assign fit   = (t >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fit ? REMW'(t - trial) : REMW'(t);
      root_q <= {root_q[QW-2:0], fit};
    end
  end

  // Round to nearest: the remainder exceeds the root when v > root^2 + root.
  assign root_o = root_q + QW'(rem_q > REMW'(root_q));
  assign done_o = done_q;

endmodule

FILE: design/pam_div.sv
// Restoring divider giving a 16-bit quotient, saturated at all ones.
// Depends on pam_pkg.
module pam_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pam_pkg::DIV_W-1:0]  num_i,
  input  logic [pam_pkg::DIV_W-1:0]  den_i,
  output logic                       done_o,
  output logic [pam_pkg::QUO_W-1:0]  quo_o
);

  localparam int unsigned DW = pam_pkg::DIV_W;
  localparam int unsigned QW = pam_pkg::QUO_W;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q;
  logic [QW-1:0] nlo_q, quo_q;
  logic [DW:0]   t;
  logic          fit, sat;

  assign t   = {rem_q, nlo_q[QW-1]};
  assign fit = (t >= {1'b0, den_q});
  assign sat = ((DW+QW)'(num_i) >= {den_i, {QW{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DW'(num_i >> QW);
      nlo_q <= num_i[QW-1:0];
      quo_q <= sat ? {QW{1'b1}} : '0;
    end else if (busy_q) begin
      rem_q <= fit ? DW'(t - {1'b0, den_q}) : DW'(t);
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[QW-2:0], fit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: design/pam_ctrl.sv
// Sequencer of the polygon measurement block: steps the datapath per vertex
// and through the closing edge and final computations. Depends on pam_pkg.
module pam_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pam_pkg::status_t  status_i,
  output pam_pkg::cmd_t     cmd_o
);

  pam_pkg::state_e   state_q, state_d;
  pam_pkg::div_sel_e sel_q, sel_d;
  logic              closing_q, closing_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pam_pkg::ST_IDLE;
      sel_q     <= pam_pkg::DIV_RND;
      closing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      closing_q <= closing_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    closing_d  = closing_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.div_sel    = sel_q;
    cmd_o.close_edge = closing_q;
    unique case (state_q)
      pam_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          closing_d     = 1'b0;
          if (status_i.cnt_full) begin
            state_d = pam_pkg::ST_CHECK;
          end else if (status_i.cnt_zero) begin
            state_d = pam_pkg::ST_UPD;
          end else begin
            state_d = pam_pkg::ST_DIFF;
          end
        end
      end
      pam_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = pam_pkg::ST_SQ;
      end
      pam_pkg::ST_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = pam_pkg::ST_ROOT_GO;
      end
      pam_pkg::ST_ROOT_GO: begin
        cmd_o.root_go = 1'b1;
        state_d       = pam_pkg::ST_ROOT;
      end
      pam_pkg::ST_ROOT: begin
        if (status_i.root_done) begin
          cmd_o.add_len = 1'b1;
          state_d       = closing_q ? pam_pkg::ST_F1 : pam_pkg::ST_UPD;
        end
      end
      pam_pkg::ST_UPD: begin
        cmd_o.upd_vtx = 1'b1;
        state_d       = pam_pkg::ST_CHECK;
      end
      pam_pkg::ST_CHECK: begin
        if (!status_i.last) begin
          state_d = pam_pkg::ST_IDLE;
        end else if (status_i.cnt_ge3) begin
          closing_d = 1'b1;
          state_d   = pam_pkg::ST_DIFF;
        end else begin
          state_d = pam_pkg::ST_OUT;
        end
      end
      pam_pkg::ST_F1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = pam_pkg::ST_F2;
      end
      pam_pkg::ST_F2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = pam_pkg::ST_F3;
      end
      pam_pkg::ST_F3: begin
        cmd_o.fin3 = 1'b1;
        state_d    = pam_pkg::ST_F4;
      end
      pam_pkg::ST_F4: begin
        cmd_o.fin4 = 1'b1;
        sel_d      = status_i.perim_zero ? pam_pkg::DIV_CX : pam_pkg::DIV_RND;
        state_d    = pam_pkg::ST_DIV_GO;
      end
      pam_pkg::ST_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = pam_pkg::ST_DIV_WAIT;
      end
      pam_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sel_q == pam_pkg::DIV_CY) begin
            state_d = pam_pkg::ST_OUT;
          end else begin
            sel_d   = (sel_q == pam_pkg::DIV_RND) ? pam_pkg::DIV_CX : pam_pkg::DIV_CY;
            state_d = pam_pkg::ST_DIV_GO;
          end
        end
      end
      pam_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = pam_pkg::ST_IDLE;
        end
      end
      default: state_d = pam_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: design/pam_datapath.sv
// Datapath of the polygon measurement block: accumulators, edge arithmetic,
// final scaling, square root and divider units, result register.
// Depends on pam_pkg, pam_sqrt and pam_div.
module pam_datapath #(
  parameter int unsigned MAX_VERTICES = pam_pkg::MAX_VERTICES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pam_pkg::MM_W-1:0]      cfg_data_i,
  input  logic [15:0]                   vertex_x_i,
  input  logic [15:0]                   vertex_y_i,
  input  logic                          last_vertex_i,
  input  pam_pkg::cmd_t                 cmd_i,
  output pam_pkg::status_t              status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [32:0]                   area_px_o,
  output logic [39:0]                   area_mm_o,
  output logic [26:0]                   perimeter_len_o,
  output logic [15:0]                   centroid_x_o,
  output logic [15:0]                   centroid_y_o,
  output logic [15:0]                   roundness_o,
  output logic [15:0]                   box_left_o,
  output logic [15:0]                   box_top_o,
  output logic [15:0]                   box_width_o,
  output logic [15:0]                   box_height_o,
  output logic                          valid_res_o
);

  localparam int unsigned CW      = pam_pkg::COORD_W;
  localparam int unsigned VCW     = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SUM_W   = CW + VCW;
  localparam int unsigned CROSS_W = 2 * CW + VCW + 2;
  localparam int unsigned AW      = pam_pkg::AREA_W;
  localparam int unsigned MW      = pam_pkg::AREA_MM_W;
  localparam int unsigned PW      = pam_pkg::PERIM_W;
  localparam int unsigned DW      = pam_pkg::DIV_W;
  localparam int unsigned QW      = pam_pkg::QUO_W;
  localparam int unsigned RDW     = pam_pkg::RAD_W;
  localparam int unsigned RTW     = pam_pkg::ROOT_W;

  // Input and configuration registers.
  logic [CW-1:0]            cur_x_q, cur_y_q;
  logic                     last_q;
  logic [pam_pkg::MM_W-1:0] mm_q;

  // Accumulators.
  logic [CW-1:0]      first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [CW-1:0]      min_x_q, min_y_q, max_x_q, max_y_q;
  logic [CROSS_W-1:0] cross_q;
  logic [SUM_W-1:0]   sum_x_q, sum_y_q;
  logic [PW-1:0]      perim_q;
  logic [VCW-1:0]     cnt_q;

  // Edge and final pipeline registers.
  logic [CW-1:0]      dx_q, dy_q;
  logic [2*CW-1:0]    p1_q, p2_q, sqx_q, sqy_q;
  logic [AW-1:0]      area_q;
  logic [MW-1:0]      mm2_q, amm_q;
  logic [AW+31:0]     plo_q;
  logic [AW+7:0]      phi_q;
  logic [2*PW-1:0]    psq_q;
  logic [AW+19:0]     rn_q;
  logic [QW-1:0]      rnd_q, cx_q, cy_q;

  logic               out_valid_q;
  logic               root_done, div_done;
  logic [RTW-1:0]     root;
  logic [QW-1:0]      quo;
  logic [DW-1:0]      div_num, div_den;

  logic [CW-1:0]      ax, ay, bx, by;
  logic [CROSS_W-1:0] mag, half;
  logic [AW-1:0]      area_sat;
  logic [PW:0]        perim_add;
  logic [MW+1:0]      amm_sum;
  logic               ge3;

  assign ge3 = (cnt_q >= VCW'(3));

  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.cnt_full   = (cnt_q >= VCW'(MAX_VERTICES));
  assign status_o.cnt_ge3    = ge3;
  assign status_o.last       = last_q;
  assign status_o.root_done  = root_done;
  assign status_o.div_done   = div_done;
  assign status_o.perim_zero = (perim_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Edge runs from the previous vertex to the new one, or back to the first.
  assign ax = prev_x_q;
  assign ay = prev_y_q;
  assign bx = cmd_i.close_edge ? first_x_q : cur_x_q;
  assign by = cmd_i.close_edge ? first_y_q : cur_y_q;

  assign mag      = cross_q[CROSS_W-1] ? CROSS_W'(-cross_q) : cross_q;
  assign half     = mag >> 1;
  assign area_sat = (|half[CROSS_W-1:AW]) ? {AW{1'b1}} : half[AW-1:0];

  assign perim_add = (PW+1)'(perim_q) + (PW+1)'(root);
  assign amm_sum   = (MW+2)'(plo_q[AW+31:32]) + (MW+2)'(phi_q);

  always_comb begin
    case (cmd_i.div_sel)
      pam_pkg::DIV_RND: begin
        div_num = DW'(rn_q);
        div_den = DW'(psq_q);
      end
      pam_pkg::DIV_CX: begin
        div_num = DW'(sum_x_q + SUM_W'(cnt_q >> 1));
        div_den = DW'(cnt_q);
      end
      default: begin
        div_num = DW'(sum_y_q + SUM_W'(cnt_q >> 1));
        div_den = DW'(cnt_q);
      end
    endcase
  end

  pam_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_go),
    .rad_i   (RDW'(sqx_q) + RDW'(sqy_q)),
    .done_o  (root_done),
    .root_o  (root)
  );

  pam_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_q        <= pam_pkg::MM_RESET;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      cross_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      perim_q     <= '0;
      cnt_q       <= '0;
      min_x_q     <= '1;
      min_y_q     <= '1;
      max_x_q     <= '0;
      max_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mm_q <= cfg_data_i;
      end
      if (cmd_i.square) begin
        cross_q <= cross_q + CROSS_W'(p1_q) - CROSS_W'(p2_q);
      end
      if (cmd_i.add_len) begin
        perim_q <= perim_add[PW] ? {PW{1'b1}} : perim_add[PW-1:0];
      end
      if (cmd_i.upd_vtx) begin
        if (cnt_q == '0) begin
          first_x_q <= cur_x_q;
          first_y_q <= cur_y_q;
        end
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
        sum_x_q  <= sum_x_q + SUM_W'(cur_x_q);
        sum_y_q  <= sum_y_q + SUM_W'(cur_y_q);
        if (cur_x_q < min_x_q) min_x_q <= cur_x_q;
        if (cur_y_q < min_y_q) min_y_q <= cur_y_q;
        if (cur_x_q > max_x_q) max_x_q <= cur_x_q;
        if (cur_y_q > max_y_q) max_y_q <= cur_y_q;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        first_x_q   <= '0;
        first_y_q   <= '0;
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        cross_q     <= '0;
        sum_x_q     <= '0;
        sum_y_q     <= '0;
        perim_q     <= '0;
        cnt_q       <= '0;
        min_x_q     <= '1;
        min_y_q     <= '1;
        max_x_q     <= '0;
        max_y_q     <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_x_q <= vertex_x_i;
      cur_y_q <= vertex_y_i;
      last_q  <= last_vertex_i;
    end
    if (cmd_i.diff) begin
      dx_q <= (ax > bx) ? ax - bx : bx - ax;
      dy_q <= (ay > by) ? ay - by : by - ay;
      p1_q <= (2*CW)'(ax) * (2*CW)'(by);
      p2_q <= (2*CW)'(bx) * (2*CW)'(ay);
    end
    if (cmd_i.square) begin
      sqx_q <= (2*CW)'(dx_q) * (2*CW)'(dx_q);
      sqy_q <= (2*CW)'(dy_q) * (2*CW)'(dy_q);
    end
    if (cmd_i.fin1) begin
      area_q <= area_sat;
      mm2_q  <= MW'(mm_q) * MW'(mm_q);
    end
    if (cmd_i.fin2) begin
      plo_q <= (AW+32)'(area_q) * (AW+32)'(mm2_q[31:0]);
      psq_q <= (2*PW)'(perim_q) * (2*PW)'(perim_q);
    end
    if (cmd_i.fin3) begin
      phi_q <= (AW+8)'(area_q) * (AW+8)'(mm2_q[MW-1:32]);
      rn_q  <= (AW+20)'(area_q) * (AW+20)'(pam_pkg::FOUR_PI_Q16);
      rnd_q <= '0;
    end
    if (cmd_i.fin4) begin
      amm_q <= (|amm_sum[MW+1:MW]) ? {MW{1'b1}} : amm_sum[MW-1:0];
    end
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        pam_pkg::DIV_RND: rnd_q <= quo;
        pam_pkg::DIV_CX:  cx_q  <= quo;
        default:          cy_q  <= quo;
      endcase
    end
    if (cmd_i.out_load) begin
      if (ge3) begin
        area_px_o       <= area_q;
        area_mm_o       <= amm_q;
        perimeter_len_o <= perim_q;
        centroid_x_o    <= cx_q;
        centroid_y_o    <= cy_q;
        roundness_o     <= rnd_q;
        box_left_o      <= min_x_q;
        box_top_o       <= min_y_q;
        box_width_o     <= max_x_q - min_x_q;
        box_height_o    <= max_y_q - min_y_q;
        valid_res_o     <= (area_q != '0);
      end else begin
        area_px_o       <= '0;
        area_mm_o       <= '0;
        perimeter_len_o <= '0;
        centroid_x_o    <= '0;
        centroid_y_o    <= '0;
        roundness_o     <= '0;
        box_left_o      <= '0;
        box_top_o       <= '0;
        box_width_o     <= '0;
        box_height_o    <= '0;
        valid_res_o     <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/pam_checker.sv
// Port-level checks of the polygon measurement block, bound to the top level.
// Depends on polygon_area_perimeter_measure_core and its interfaces.
module pam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [32:0] area_px_i,
  input logic [39:0] area_mm_i,
  input logic [15:0] roundness_i,
  input logic [15:0] box_left_i,
  input logic [15:0] box_width_i,
  input logic        valid_res_i
);

  // A stalled result keeps its area.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(area_px_i))
    else $error("result changed while stalled");

  // Each vertex is processed before the next is taken, so input is never taken twice in a row.
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("vertex taken in consecutive cycles");

  a_valid_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && valid_res_i |-> area_px_i != 33'd0)
    else $error("valid result with zero area");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |-> area_px_i == 33'd0 && area_mm_i == 40'd0 &&
                                   roundness_i == 16'd0)
    else $error("invalid result carries area");

  a_box_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, box_left_i} + {1'b0, box_width_i}) <= 17'h0FFFF)
    else $error("bounding box exceeds coordinate range");

endmodule

bind polygon_area_perimeter_measure_core pam_checker u_pam_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vtx_i.valid),
  .in_ready_i  (vtx_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .area_px_i   (res_o.area_px),
  .area_mm_i   (res_o.area_mm),
  .roundness_i (res_o.roundness),
  .box_left_i  (res_o.box_left),
  .box_width_i (res_o.box_width),
  .valid_res_i (res_o.valid_res)
);
